[design/qod_pkg.sv]
// Package for the quadrilateral orientation block: widths, angle constants,
// the arctangent table and the shared payload types. Depends on nothing.
`default_nettype none

package qod_pkg;

  // Angles are in degrees with sixteen fractional bits.
  localparam int ANG_FRAC     = 16;
  localparam int CORDIC_STEPS = 23;
  // Magnitudes are normalised so that the larger one lies in [2^40, 2^41).
  localparam int NORM_BITS    = 40;
  localparam int NORM_W       = NORM_BITS + 1;
  // Rotation datapath: the gain of about 1.65 on a 2^41.5 vector needs 43 bits
  // of magnitude plus sign and a spare bit.
  localparam int XY_W         = 45;
  localparam int Z_W          = 25;
  localparam int MAG_W        = Z_W - 1;
  localparam int DEG_W        = 9;

  localparam logic [MAG_W-1:0] Z_90   = MAG_W'(90 << ANG_FRAC);
  localparam logic [MAG_W-1:0] Z_180  = MAG_W'(180 << ANG_FRAC);
  localparam logic [MAG_W-1:0] Z_HALF = MAG_W'(1 << (ANG_FRAC - 1));

  typedef struct packed {
    logic zero;
    logic dx_neg;
    logic dy_neg;
  } qod_flags_t;

  typedef struct packed {
    logic [NORM_W-1:0] a;
    logic [NORM_W-1:0] b;
  } qod_pair_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } qod_vec_t;

  // atan(2^-i) in degrees, scaled by 2^16 and rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = 25'sd2949120;
      1:       v = 25'sd1740967;
      2:       v = 25'sd919879;
      3:       v = 25'sd466945;
      4:       v = 25'sd234379;
      5:       v = 25'sd117304;
      6:       v = 25'sd58666;
      7:       v = 25'sd29335;
      8:       v = 25'sd14668;
      9:       v = 25'sd7334;
      10:      v = 25'sd3667;
      11:      v = 25'sd1833;
      12:      v = 25'sd917;
      13:      v = 25'sd458;
      14:      v = 25'sd229;
      15:      v = 25'sd115;
      16:      v = 25'sd57;
      17:      v = 25'sd29;
      18:      v = 25'sd14;
      19:      v = 25'sd7;
      20:      v = 25'sd4;
      21:      v = 25'sd2;
      22:      v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One step of the leading-one normalisation: shift both magnitudes left by
  // k when the top k bits of both are clear.
  function automatic qod_pair_t norm_shift(input qod_pair_t p, input int k);
    qod_pair_t r;
    r = p;
    if (((p.a | p.b) >> (NORM_W - k)) == '0) begin
      r.a = p.a << k;
      r.b = p.b << k;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/quad_orientation_degrees.sv]
// Top level of the quadrilateral orientation block: direction of the centre
// line in whole degrees. Depends on qod_pkg, qod_front, qod_cordic_stage, qod_back.
//
//   Channel   Ports                               Direction   Transaction
//   input     in_valid, in_stall, in_corner*_*    in          one quadrilateral
//   result    out_valid, out_stall, out_angle_*   out         one angle
//
// Throughput is one transaction per clock on each side while out_stall is low. The
// pipeline is five front-end stages (vector sums, magnitudes, three normalisation
// stages), one stage for each of the 23 unrolled CORDIC rotations, and three
// back-end stages ending in the output register.
// Reset is synchronous and active low; it clears every stage's valid bit only.
// Each stage loads when it is empty or its contents move on, so bubbles are
// squeezed out under out_stall and in_stall rises only when all stages are full.
`default_nettype none

module quad_orientation_degrees
  import qod_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_corner0_x,
  input  wire logic signed [COORD_BITS-1:0] in_corner0_y,
  input  wire logic signed [COORD_BITS-1:0] in_corner1_x,
  input  wire logic signed [COORD_BITS-1:0] in_corner1_y,
  input  wire logic signed [COORD_BITS-1:0] in_corner2_x,
  input  wire logic signed [COORD_BITS-1:0] in_corner2_y,
  input  wire logic signed [COORD_BITS-1:0] in_corner3_x,
  input  wire logic signed [COORD_BITS-1:0] in_corner3_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DEG_W-1:0]           out_angle_degrees
);

  logic       front_ready;
  qod_pair_t  front_pair;

  // Index k is the input of rotation k; index CORDIC_STEPS feeds the back end.
  logic       v   [CORDIC_STEPS+1];
  logic       rdy [CORDIC_STEPS+1];
  qod_vec_t   vec [CORDIC_STEPS+1];
  qod_flags_t fl  [CORDIC_STEPS+1];

  qod_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .c0_x      (in_corner0_x),
    .c0_y      (in_corner0_y),
    .c1_x      (in_corner1_x),
    .c1_y      (in_corner1_y),
    .c2_x      (in_corner2_x),
    .c2_y      (in_corner2_y),
    .c3_x      (in_corner3_x),
    .c3_y      (in_corner3_y),
    .out_valid (v[0]),
    .out_ready (rdy[0]),
    .out_pair  (front_pair),
    .out_flags (fl[0])
  );

  // The normalised magnitudes enter the rotations as non-negative x and y,
  // with the accumulated angle starting at zero.
  always_comb begin
    vec[0].x = XY_W'(front_pair.a);
    vec[0].y = XY_W'(front_pair.b);
    vec[0].z = '0;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    qod_cordic_stage #(
      .STEP (k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[k]),
      .in_ready  (rdy[k]),
      .in_vec    (vec[k]),
      .in_flags  (fl[k]),
      .out_valid (v[k+1]),
      .out_ready (rdy[k+1]),
      .out_vec   (vec[k+1]),
      .out_flags (fl[k+1])
    );
  end

  qod_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v[CORDIC_STEPS]),
    .in_ready  (rdy[CORDIC_STEPS]),
    .in_vec    (vec[CORDIC_STEPS]),
    .in_flags  (fl[CORDIC_STEPS]),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_angle (out_angle_degrees)
  );

  assign in_stall = !front_ready;

  // A delivered angle always lies within a half turn either way.
  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_angle_degrees) >= -180) &&
                  ($signed(out_angle_degrees) <= 180))
    else $error("angle outside -180..180");

  // The input can only be held off when the output register is full and held.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output side can move");

  // Reset empties the pipeline.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

`default_nettype wire

[design/qod_front.sv]
// Front end of the orientation pipeline: centre-line vector, magnitudes and
// leading-one normalisation over five stages. Depends on qod_pkg.
`default_nettype none

module qod_front
  import qod_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] c0_x,
  input  wire logic signed [COORD_BITS-1:0] c0_y,
  input  wire logic signed [COORD_BITS-1:0] c1_x,
  input  wire logic signed [COORD_BITS-1:0] c1_y,
  input  wire logic signed [COORD_BITS-1:0] c2_x,
  input  wire logic signed [COORD_BITS-1:0] c2_y,
  input  wire logic signed [COORD_BITS-1:0] c3_x,
  input  wire logic signed [COORD_BITS-1:0] c3_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output qod_pair_t                         out_pair,
  output qod_flags_t                        out_flags
);

  localparam int SW = COORD_BITS + 2;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                 ld1, ld2, ld3, ld4, ld5;
  logic signed [SW-1:0] dx_r, dy_r;
  logic signed [SW-1:0] dx_nxt, dy_nxt;
  logic [SW-1:0]        ax, ay;
  qod_pair_t            pair2_r, pair3_r, pair4_r, pair5_r;
  qod_pair_t            pair2_nxt;
  qod_flags_t           fl2_r, fl3_r, fl4_r, fl5_r;
  qod_flags_t           fl2_nxt;

  // A stage loads when it is empty or its content moves on.
  assign ld5      = !v5_r || out_ready;
  assign ld4      = !v4_r || ld5;
  assign ld3      = !v3_r || ld4;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  always_comb begin
    dx_nxt = (SW'(c1_x) + SW'(c2_x)) - (SW'(c0_x) + SW'(c3_x));
    dy_nxt = (SW'(c1_y) + SW'(c2_y)) - (SW'(c0_y) + SW'(c3_y));
  end

  always_comb begin
    ax = dx_r[SW-1] ? SW'(-dx_r) : SW'(dx_r);
    ay = dy_r[SW-1] ? SW'(-dy_r) : SW'(dy_r);
    pair2_nxt.a    = NORM_W'(ax);
    pair2_nxt.b    = NORM_W'(ay);
    fl2_nxt.zero   = (dx_r == '0) && (dy_r == '0);
    fl2_nxt.dx_neg = dx_r[SW-1];
    fl2_nxt.dy_neg = dy_r[SW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (ld2) begin
      pair2_r <= pair2_nxt;
      fl2_r   <= fl2_nxt;
    end
    if (ld3) begin
      pair3_r <= norm_shift(norm_shift(pair2_r, 32), 16);
      fl3_r   <= fl2_r;
    end
    if (ld4) begin
      pair4_r <= norm_shift(norm_shift(pair3_r, 8), 4);
      fl4_r   <= fl3_r;
    end
    if (ld5) begin
      pair5_r <= norm_shift(norm_shift(pair4_r, 2), 1);
      fl5_r   <= fl4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_pair  = pair5_r;
  assign out_flags = fl5_r;

endmodule

`default_nettype wire

[design/qod_cordic_stage.sv]
// One registered vectoring rotation of the CORDIC arctangent pipeline.
// Depends on qod_pkg for the datapath types and the arctangent table.
`default_nettype none

module qod_cordic_stage
  import qod_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire qod_vec_t   in_vec,
  input  wire qod_flags_t in_flags,
  output logic            out_valid,
  input  wire logic       out_ready,
  output qod_vec_t        out_vec,
  output qod_flags_t      out_flags
);

  logic                   v_r;
  logic                   ld;
  qod_vec_t               vec_r, vec_nxt;
  qod_flags_t             fl_r;
  logic signed [XY_W-1:0] xs, ys;

  assign ld       = !v_r || out_ready;
  assign in_ready = ld;

  // Rotate towards the x axis; the sign of y picks the direction.
  always_comb begin
    xs = in_vec.x >>> STEP;
    ys = in_vec.y >>> STEP;
    if (!in_vec.y[XY_W-1]) begin
      vec_nxt.x = in_vec.x + ys;
      vec_nxt.y = in_vec.y - xs;
      vec_nxt.z = in_vec.z + atan_entry(STEP);
    end else begin
      vec_nxt.x = in_vec.x - ys;
      vec_nxt.y = in_vec.y + xs;
      vec_nxt.z = in_vec.z - atan_entry(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ld) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      vec_r <= vec_nxt;
      fl_r  <= in_flags;
    end
  end

  assign out_valid = v_r;
  assign out_vec   = vec_r;
  assign out_flags = fl_r;

endmodule

`default_nettype wire

[design/qod_back.sv]
// Back end of the orientation pipeline: clamp, quadrant mapping and rounding
// to whole degrees over three stages, the last being the output register.
// Depends on qod_pkg.
`default_nettype none

module qod_back
  import qod_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire qod_vec_t          in_vec,
  input  wire qod_flags_t        in_flags,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [DEG_W-1:0] out_angle
);

  logic                    v1_r, v2_r, v3_r;
  logic                    ld1, ld2, ld3;
  logic [MAG_W-1:0]        zc_r, zc_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  qod_flags_t              fl1_r, fl2_r;
  logic [MAG_W-1:0]        rnd;
  logic [DEG_W-1:0]        deg;
  logic signed [DEG_W-1:0] angle_r, angle_nxt;

  assign ld3      = !v3_r || out_ready;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  always_comb begin
    if (in_vec.z[Z_W-1]) begin
      zc_nxt = '0;
    end else if (in_vec.z[Z_W-2:0] > Z_90) begin
      zc_nxt = Z_90;
    end else begin
      zc_nxt = in_vec.z[Z_W-2:0];
    end
  end

  assign mag_nxt = fl1_r.dx_neg ? (Z_180 - zc_r) : zc_r;

  // Round the magnitude half away from zero, then apply the sign.
  always_comb begin
    rnd = mag_r + Z_HALF;
    deg = DEG_W'(rnd[MAG_W-1:ANG_FRAC]);
    if (fl2_r.zero) begin
      angle_nxt = '0;
    end else if (fl2_r.dy_neg) begin
      angle_nxt = -$signed(deg);
    end else begin
      angle_nxt = $signed(deg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      zc_r  <= zc_nxt;
      fl1_r <= in_flags;
    end
    if (ld2) begin
      mag_r <= mag_nxt;
      fl2_r <= fl1_r;
    end
    if (ld3) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_angle = angle_r;

endmodule

`default_nettype wire
